// ----- hdl/uxs_pkg.sv -----
// Shared types, constants and helpers for the UTF-8 XML text sanitizer.
// Used by every module under hdl; depends on nothing.
package uxs_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       chunk_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_beat_t;

  localparam int MAX_RUN = 5;
  localparam int CNT_W   = 3;
  localparam int IDX_W   = 3;

  // Output bytes caused by one input beat; bytes[0] goes out first.
  typedef struct packed {
    logic [CNT_W-1:0]          cnt;
    logic [MAX_RUN-1:0][7:0]   bytes;
  } run_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Pending sequence length codes
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  localparam logic [MAX_RUN-1:0][7:0] ESC_AMP = {8'h3B, 8'h70, 8'h6D, 8'h61, 8'h26};
  localparam logic [MAX_RUN-1:0][7:0] ESC_LT  = {8'h00, 8'h3B, 8'h74, 8'h6C, 8'h26};
  localparam logic [MAX_RUN-1:0][7:0] ESC_GT  = {8'h00, 8'h3B, 8'h74, 8'h67, 8'h26};
  localparam logic [CNT_W-1:0] ESC_AMP_LEN = 3'd5;
  localparam logic [CNT_W-1:0] ESC_LT_LEN  = 3'd4;

  function automatic logic xml_legal(input logic [20:0] cp);
    xml_legal = (cp >= 21'h000020 && cp <= 21'h00D7FF) ||
                (cp >= 21'h00E000 && cp <= 21'h00FFFD) ||
                (cp >= 21'h010000 && cp <= 21'h10FFFF);
  endfunction

endpackage

// ----- hdl/utf8_xml_text_sanitizer_unit.sv -----
// Top level of the UTF-8 XML text sanitizer: front end, run queue, back end.
// Depends on uxs_pkg, uxs_front, uxs_fifo and uxs_back.
//
// Takes one UTF-8 byte per beat and passes on only bytes legal in XML 1.0
// text, with &, < and > replaced by entity text. Each input beat is decoded
// in the cycle it is taken and produces from zero to five output bytes; a
// beat can be taken every cycle while the four-entry run queue has room.
// The output side delivers one byte per cycle while not stalled, so the
// sustained input rate is one beat per cycle for plain text and is set by
// the output port when runs exceed one byte (escapes, completed multi-byte
// sequences). run_last marks the final byte of the run caused by one input
// beat; beats that cause no output produce nothing on the output channel.
module utf8_xml_text_sanitizer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  uxs_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output uxs_pkg::out_beat_t out_data
);
  import uxs_pkg::*;

  q_stat_t q_stat;
  run_t    q_wdata;
  run_t    q_head;
  logic    q_push;
  logic    q_pop;

  uxs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  uxs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  uxs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/uxs_front.sv -----
// Front end: accepts input beats, tracks the pending UTF-8 sequence, turns
// each beat into at most one run of output bytes. Depends on uxs_pkg.
module uxs_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  uxs_pkg::in_beat_t in_data,
  input  uxs_pkg::q_stat_t  q_stat,
  output logic            q_push,
  output uxs_pkg::run_t   q_data
);
  import uxs_pkg::*;

  logic [2:0]  exp_r, exp_nxt;
  logic [1:0]  hc_r, hc_nxt;
  logic [20:0] cp_r, cp_nxt;
  logic [7:0]  held_r [3];

  logic        accept;
  logic        start;
  logic        hold_we;
  logic [1:0]  hold_idx;
  logic [20:0] cp_acc;
  logic [7:0]  b;
  run_t        run;

  assign b        = in_data.in_byte;
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign cp_acc   = {cp_r[14:0], b[5:0]};

  always_comb begin
    exp_nxt  = exp_r;
    hc_nxt   = hc_r;
    cp_nxt   = cp_r;
    hold_we  = 1'b0;
    hold_idx = 2'd0;
    start    = 1'b0;
    run      = '0;

    if (exp_r != LEN_NONE) begin
      if (b[7:6] == 2'b10) begin
        cp_nxt = cp_acc;
        if (({1'b0, hc_r} + 3'd1) >= exp_r) begin
          if (xml_legal(cp_acc)) begin
            run.cnt      = {1'b0, hc_r} + 3'd1;
            run.bytes[0] = held_r[0];
            run.bytes[1] = (hc_r == 2'd1) ? b : held_r[1];
            run.bytes[2] = (hc_r == 2'd2) ? b : held_r[2];
            run.bytes[3] = b;
          end
          exp_nxt = LEN_NONE;
          hc_nxt  = 2'd0;
          cp_nxt  = '0;
        end else if (hc_r != 2'd3) begin
          hold_we  = 1'b1;
          hold_idx = hc_r;
          hc_nxt   = hc_r + 2'd1;
        end else begin
          exp_nxt = LEN_NONE;
          hc_nxt  = 2'd0;
          cp_nxt  = '0;
        end
      end else begin
        exp_nxt = LEN_NONE;
        hc_nxt  = 2'd0;
        cp_nxt  = '0;
        start   = 1'b1;
      end
    end else begin
      start = 1'b1;
    end

    if (start) begin
      if (!b[7]) begin
        if ((b < CH_SPACE && b != CH_TAB && b != CH_LF && b != CH_CR) || b == CH_DEL) begin
          run = '0;
        end else if (b == CH_AMP) begin
          run.cnt   = ESC_AMP_LEN;
          run.bytes = ESC_AMP;
        end else if (b == CH_LT) begin
          run.cnt   = ESC_LT_LEN;
          run.bytes = ESC_LT;
        end else if (b == CH_GT) begin
          run.cnt   = ESC_LT_LEN;
          run.bytes = ESC_GT;
        end else begin
          run.cnt      = 3'd1;
          run.bytes[0] = b;
        end
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
        exp_nxt = LEN_2;
        cp_nxt  = {16'd0, b[4:0]};
        hc_nxt  = 2'd1;
        hold_we = 1'b1;
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
        exp_nxt = LEN_3;
        cp_nxt  = {17'd0, b[3:0]};
        hc_nxt  = 2'd1;
        hold_we = 1'b1;
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
        exp_nxt = LEN_4;
        cp_nxt  = {18'd0, b[2:0]};
        hc_nxt  = 2'd1;
        hold_we = 1'b1;
      end
    end

    if (in_data.chunk_end) begin
      exp_nxt = LEN_NONE;
      hc_nxt  = 2'd0;
      cp_nxt  = '0;
    end
  end

  assign q_push = accept && (run.cnt != '0);
  assign q_data = run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= LEN_NONE;
      hc_r  <= 2'd0;
      cp_r  <= '0;
    end else if (accept) begin
      exp_r <= exp_nxt;
      hc_r  <= hc_nxt;
      cp_r  <= cp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_we) begin
      held_r[hold_idx] <= b;
    end
  end

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_data.cnt >= 3'd1 && q_data.cnt <= 3'd5))
    else $error("run length out of range");

  a_len_count: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_r == LEN_NONE) |-> (hc_r == 2'd0))
    else $error("held bytes without pending sequence");

  a_pending_count: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_r != LEN_NONE) |-> (hc_r != 2'd0 && {1'b0, hc_r} < exp_r))
    else $error("held count inconsistent with sequence length");

endmodule

// ----- hdl/uxs_fifo.sv -----
// Short queue of byte runs between front and back end.
// Depends on uxs_pkg.
module uxs_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  uxs_pkg::run_t    push_data,
  input  logic             pop,
  output uxs_pkg::run_t    head,
  output uxs_pkg::q_stat_t stat
);
  import uxs_pkg::*;

  run_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> !pop)
    else $error("pop from empty queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= QCNT_W'(QDEPTH)) && (QPTR_W'(wr_r - rd_r) == cnt_r[QPTR_W-1:0]))
    else $error("queue pointers disagree with count");

endmodule

// ----- hdl/uxs_back.sv -----
// Back end: walks the run at the queue head one byte per beat into the
// output register and flags the last byte of each run. Depends on uxs_pkg.
module uxs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  uxs_pkg::q_stat_t   q_stat,
  input  uxs_pkg::run_t      q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output uxs_pkg::out_beat_t out_data
);
  import uxs_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_data_r;
  logic             load;
  logic             last;

  assign load  = !q_stat.empty && (!out_valid_r || !out_stall);
  assign last  = ((idx_r + 3'd1) == q_head.cnt);
  assign q_pop = load && last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = last ? '0 : idx_r + 3'd1;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.out_byte <= q_head.bytes[idx_r];
      out_data_r.run_last <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.empty |-> (idx_r < q_head.cnt))
    else $error("byte index beyond run length");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> (idx_r == '0))
    else $error("byte index left mid-run with empty queue");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid && out_data.run_last))
    else $error("run popped without last flag");

endmodule
